/* design/ddd_pkg.sv */
// ddd_pkg: shared types, constants and calendar helpers for the date difference block
// used by ddd_rom, ddd_seq, ddd_dpath and date_difference_in_days_top
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

  // field widths
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int CNT_W  = 23;
  localparam int ACC_W  = 24;
  localparam int STEP_W = 4;
  localparam int SRC_W  = 12;
  localparam int Q_W    = 8;
  localparam int PROD_W = 23;
  localparam int MD_W   = 10;

  // calendar constants
  localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
  localparam logic [MON_W-1:0]  MON_FEB    = 4'd2;
  localparam logic [MON_W-1:0]  MON_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]  FEB_LEAP   = 5'd29;
  localparam logic [ACC_W-1:0]  DAYS_YEAR  = 24'd365;

  // floor(x / 25) for x < 4096 as (x * 1311) >> 15
  localparam logic [10:0] DIV25_MUL = 11'd1311;
  localparam int          DIV25_SH  = 15;

  // quotient source codes
  localparam logic [2:0] QS_NONE = 3'd0;
  localparam logic [2:0] QS_Y2   = 3'd1;  // year / 4, leap check
  localparam logic [2:0] QS_Y4   = 3'd2;  // year / 16, leap check
  localparam logic [2:0] QS_YS2  = 3'd3;  // march-based year / 4
  localparam logic [2:0] QS_YS4  = 3'd4;  // march-based year / 16

  // accumulator operation codes
  localparam logic [1:0] AO_NONE   = 2'd0;
  localparam logic [1:0] AO_YEAR   = 2'd1;  // 365*ys + ys/4
  localparam logic [1:0] AO_SUBQ   = 2'd2;  // - ys/100
  localparam logic [1:0] AO_ADDQMD = 2'd3;  // + ys/400 + month offset + day - 1

  // jump condition codes
  localparam logic JC_NONE = 1'b0;
  localparam logic JC_BAD  = 1'b1;

  // step numbers
  localparam logic [STEP_W-1:0] STEP_FIN = 4'd10;

  typedef struct packed {
    logic [YEAR_W-1:0] start_year;
    logic [MON_W-1:0]  start_month;
    logic [DAY_W-1:0]  start_day;
    logic [YEAR_W-1:0] end_year;
    logic [MON_W-1:0]  end_month;
    logic [DAY_W-1:0]  end_day;
    logic              include_end;
  } in_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] day_count;
    logic                    invalid_date;
  } out_t;

  // one microcode word
  typedef struct packed {
    logic              sel_end;
    logic [2:0]        qsrc;
    logic [1:0]        acc_op;
    logic              leap_wr;
    logic              fin;
    logic              jmp;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic bad_field;
  } stat_t;

  // days from march 1 to the first of the month
  function automatic logic [8:0] month_offset(input logic [MON_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // month length with leap february
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:    r = leap ? FEB_LEAP : 5'd28;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // year, month and day-nonzero range check
  function automatic logic fields_ok(input logic [YEAR_W-1:0] y,
                                     input logic [MON_W-1:0] m,
                                     input logic [DAY_W-1:0] d);
    logic r;
    r = (y inside {[14'd1:YEAR_MAX]}) && (m inside {[4'd1:MON_DEC]}) && (d != '0);
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ddd_rom.sv */
// ddd_rom: microcode program, one control word per step
// depends on ddd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ddd_rom (
  input  wire logic [ddd_pkg::STEP_W-1:0] step,
  output ddd_pkg::ctl_t                   ctl
);

  // end date adds its day number, start date subtracts it
  always_comb begin
    case (step)
      4'd0: ctl = '{sel_end: 1'b1, qsrc: ddd_pkg::QS_Y2, acc_op: ddd_pkg::AO_NONE,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_BAD,
                    target: ddd_pkg::STEP_FIN};
      4'd1: ctl = '{sel_end: 1'b1, qsrc: ddd_pkg::QS_Y4, acc_op: ddd_pkg::AO_YEAR,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd2: ctl = '{sel_end: 1'b1, qsrc: ddd_pkg::QS_YS2, acc_op: ddd_pkg::AO_NONE,
                    leap_wr: 1'b1, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd3: ctl = '{sel_end: 1'b1, qsrc: ddd_pkg::QS_YS4, acc_op: ddd_pkg::AO_SUBQ,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd4: ctl = '{sel_end: 1'b1, qsrc: ddd_pkg::QS_NONE, acc_op: ddd_pkg::AO_ADDQMD,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd5: ctl = '{sel_end: 1'b0, qsrc: ddd_pkg::QS_Y2, acc_op: ddd_pkg::AO_NONE,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd6: ctl = '{sel_end: 1'b0, qsrc: ddd_pkg::QS_Y4, acc_op: ddd_pkg::AO_YEAR,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd7: ctl = '{sel_end: 1'b0, qsrc: ddd_pkg::QS_YS2, acc_op: ddd_pkg::AO_NONE,
                    leap_wr: 1'b1, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd8: ctl = '{sel_end: 1'b0, qsrc: ddd_pkg::QS_YS4, acc_op: ddd_pkg::AO_SUBQ,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      4'd9: ctl = '{sel_end: 1'b0, qsrc: ddd_pkg::QS_NONE, acc_op: ddd_pkg::AO_ADDQMD,
                    leap_wr: 1'b0, fin: 1'b0, jmp: ddd_pkg::JC_NONE, target: '0};
      default: ctl = '{sel_end: 1'b0, qsrc: ddd_pkg::QS_NONE, acc_op: ddd_pkg::AO_NONE,
                       leap_wr: 1'b0, fin: 1'b1, jmp: ddd_pkg::JC_NONE, target: '0};
    endcase
  end

endmodule

`default_nettype wire

/* design/ddd_seq.sv */
// ddd_seq: step counter with conditional jumps, fetches control words from ddd_rom
// depends on ddd_pkg and ddd_rom
`timescale 1ns / 1ps
`default_nettype none

module ddd_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire ddd_pkg::stat_t st,
  output ddd_pkg::ctl_t       ctl,
  output logic                busy,
  output logic                fin_fire
);

  logic                       busy_r, busy_nxt;
  logic [ddd_pkg::STEP_W-1:0] step_r, step_nxt;
  ddd_pkg::ctl_t              rom_ctl;
  logic                       jump;

  ddd_rom u_rom (
    .step (step_r),
    .ctl  (rom_ctl)
  );

  // idle steps issue no operations
  assign ctl      = busy_r ? rom_ctl : '0;
  assign busy     = busy_r;
  assign fin_fire = busy_r && rom_ctl.fin && out_free;

  // jump condition decode
  always_comb begin
    case (ctl.jmp)
      ddd_pkg::JC_NONE: jump = 1'b0;
      ddd_pkg::JC_BAD:  jump = st.bad_field;
      default:          jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (in_fire) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (rom_ctl.fin) begin
      if (out_free) begin
        busy_nxt = 1'b0;
      end
    end else if (jump) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/ddd_dpath.sv */
// ddd_dpath: operand registers, divide-by-25 unit, leap flags and day accumulator
// depends on ddd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ddd_dpath (
  input  wire logic          clk,
  input  wire logic          in_load,
  input  wire ddd_pkg::in_t  in_data,
  input  wire ddd_pkg::ctl_t ctl,
  output ddd_pkg::stat_t     st,
  output ddd_pkg::out_t      res
);

  ddd_pkg::in_t                     in_r;
  logic signed [ddd_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [ddd_pkg::Q_W-1:0]          q_r;
  logic                             z100_r, z400_r;
  logic                             leap_s_r, leap_e_r;

  logic [ddd_pkg::YEAR_W-1:0]       y, ys;
  logic [ddd_pkg::MON_W-1:0]        m;
  logic [ddd_pkg::DAY_W-1:0]        d;
  logic [ddd_pkg::SRC_W-1:0]        src;
  logic [ddd_pkg::PROD_W-1:0]       prod;
  logic [ddd_pkg::Q_W-1:0]          q;
  logic                             rem0;
  logic                             leap;
  logic [ddd_pkg::ACC_W-1:0]        ys_ext, year_term;
  logic [ddd_pkg::MD_W-1:0]         md_term;
  logic signed [ddd_pkg::ACC_W-1:0] term, term_s;
  logic                             bad_s, bad_e, bad;
  logic signed [ddd_pkg::ACC_W-1:0] cnt;

  // operand select for the current date
  assign y  = ctl.sel_end ? in_r.end_year  : in_r.start_year;
  assign m  = ctl.sel_end ? in_r.end_month : in_r.start_month;
  assign d  = ctl.sel_end ? in_r.end_day   : in_r.start_day;
  assign ys = (m <= ddd_pkg::MON_FEB) ? (y - 1'b1) : y;

  // divide-by-25 source
  always_comb begin
    case (ctl.qsrc)
      ddd_pkg::QS_Y2:  src = y[ddd_pkg::YEAR_W-1:2];
      ddd_pkg::QS_Y4:  src = ddd_pkg::SRC_W'(y[ddd_pkg::YEAR_W-1:4]);
      ddd_pkg::QS_YS2: src = ys[ddd_pkg::YEAR_W-1:2];
      ddd_pkg::QS_YS4: src = ddd_pkg::SRC_W'(ys[ddd_pkg::YEAR_W-1:4]);
      default:         src = '0;
    endcase
  end

  // reciprocal multiply and exact-multiple check
  assign prod = ddd_pkg::PROD_W'(src) * ddd_pkg::PROD_W'(ddd_pkg::DIV25_MUL);
  assign q    = prod[ddd_pkg::DIV25_SH +: ddd_pkg::Q_W];
  assign rem0 = ({1'b0, src} == (13'({q, 4'b0}) + 13'({q, 3'b0}) + 13'(q)));

  // leap from the two century flags
  assign leap = (y[1:0] == 2'b00) && (!z100_r || z400_r);

  // accumulator terms
  assign ys_ext    = ddd_pkg::ACC_W'(ys);
  assign year_term = ys_ext * ddd_pkg::DAYS_YEAR + (ys_ext >> 2);
  assign md_term   = ddd_pkg::MD_W'(q_r) + ddd_pkg::MD_W'(ddd_pkg::month_offset(m))
                   + ddd_pkg::MD_W'(d) - 1'b1;

  always_comb begin
    case (ctl.acc_op)
      ddd_pkg::AO_YEAR:   term = $signed(year_term);
      ddd_pkg::AO_SUBQ:   term = -$signed(ddd_pkg::ACC_W'(q_r));
      ddd_pkg::AO_ADDQMD: term = $signed(ddd_pkg::ACC_W'(md_term));
      default:            term = '0;
    endcase
    term_s  = ctl.sel_end ? term : -term;
    acc_nxt = acc_r + term_s;
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_r  <= in_data;
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
    if (ctl.qsrc != ddd_pkg::QS_NONE) begin
      q_r <= q;
    end
    if (ctl.qsrc == ddd_pkg::QS_Y2) begin
      z100_r <= (y[1:0] == 2'b00) && rem0;
    end
    if (ctl.qsrc == ddd_pkg::QS_Y4) begin
      z400_r <= (y[3:0] == 4'b0000) && rem0;
    end
    if (ctl.leap_wr) begin
      if (ctl.sel_end) begin
        leap_e_r <= leap;
      end else begin
        leap_s_r <= leap;
      end
    end
  end

  // validity of both dates
  assign bad_s = !ddd_pkg::fields_ok(in_r.start_year, in_r.start_month, in_r.start_day);
  assign bad_e = !ddd_pkg::fields_ok(in_r.end_year, in_r.end_month, in_r.end_day);
  assign st.bad_field = bad_s || bad_e;
  assign bad = bad_s || bad_e
            || (in_r.start_day > ddd_pkg::month_days(in_r.start_month, leap_s_r))
            || (in_r.end_day > ddd_pkg::month_days(in_r.end_month, leap_e_r));

  // include-end moves the count one step away from zero
  always_comb begin
    cnt = acc_r;
    if (in_r.include_end) begin
      cnt = (acc_r < 0) ? (acc_r - 1'b1) : (acc_r + 1'b1);
    end
    res.invalid_date = bad;
    res.day_count    = bad ? '0 : cnt[ddd_pkg::CNT_W-1:0];
  end

endmodule

`default_nettype wire

/* design/date_difference_in_days_top.sv */
// date_difference_in_days_top: signed gregorian day count between two dates
// depends on ddd_pkg, ddd_seq and ddd_dpath
//
// input channel: in_valid / in_stall with in_data (start and end year, month, day and
// the include-end flag). result channel: out_valid / out_stall with out_data
// (signed day_count and invalid_date). a transfer happens at a clock edge with valid
// high and stall low.
// one date pair is processed at a time by a microcoded sequencer: ten datapath steps
// (five per date: two leap checks and three day-number terms, with every quotient from
// a shared divide-by-25 multiplier) plus one finish step. an item holds the block from
// its input transfer until its finish step writes the output register, where out_valid
// rises; only then can the next input transfer. a pair with an out-of-range year,
// month or zero day jumps straight to the finish step and skips the other steps.
// in_stall stays high while an item is in flight. the finished result sits in an
// output register; a new item is accepted while that result waits. if the receiver
// stalls and the register is still full, the finish step holds until it drains.
// reset (rst_n low, synchronous) empties the block: no item in flight, out_valid low.
`timescale 1ns / 1ps
`default_nettype none

module date_difference_in_days_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ddd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ddd_pkg::out_t      out_data
);

  ddd_pkg::ctl_t  ctl;
  ddd_pkg::stat_t st;
  ddd_pkg::out_t  res;
  ddd_pkg::out_t  out_data_r;
  logic           out_valid_r;
  logic           busy, fin_fire, in_fire, out_free;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  ddd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .st       (st),
    .ctl      (ctl),
    .busy     (busy),
    .fin_fire (fin_fire)
  );

  ddd_dpath u_dpath (
    .clk     (clk),
    .in_load (in_fire),
    .in_data (in_data),
    .ctl     (ctl),
    .st      (st),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new result only comes from a finish step
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_fire))
    else $error("result appeared without a finish step");

  // an item in flight is not dropped before it finishes
  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !fin_fire) |=> busy)
    else $error("item lost before finish");

  // an invalid pair reports a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.invalid_date) |-> (out_data_r.day_count == '0))
    else $error("invalid result with nonzero count");

  // a finish step never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fin_fire)
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
